@@ rtl/gf32pe_pkg.sv @@
package gf32pe_pkg;

	localparam int DATA_W      = 32;
	localparam int COEF_COUNT  = 8;
	localparam int DEGREE      = 7;
	localparam int DEGREE_USED = (DEGREE < 1) ? 1 :
		((DEGREE > COEF_COUNT - 1) ? COEF_COUNT - 1 : DEGREE);
	localparam int COEF_IDX_W  = $clog2(COEF_COUNT);
	localparam int CFG_INDEX_W = COEF_IDX_W + 1;

	// x^32 + x^7 + x^3 + x^2 + 1, the part below x^32
	localparam logic [7:0] RED_POLY_LOW = 8'h8D;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	function automatic logic [DATA_W-1:0] gf_mul(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [2*DATA_W-2:0] prod;
		logic [DATA_W+5:0]   fold1;
		logic [DATA_W-1:0]   fold2;
		prod = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (b[i])
				prod = prod ^ ((2*DATA_W-1)'(a) << i);
		end
		fold1 = {6'd0, prod[DATA_W-1:0]};
		for (int i = 0; i < 8; i++) begin
			if (RED_POLY_LOW[i])
				fold1 = fold1 ^ ((DATA_W+6)'(prod[2*DATA_W-2:DATA_W]) << i);
		end
		fold2 = fold1[DATA_W-1:0];
		for (int i = 0; i < 8; i++) begin
			if (RED_POLY_LOW[i])
				fold2 = fold2 ^ (DATA_W'(fold1[DATA_W+5:DATA_W]) << i);
		end
		return fold2;
	endfunction

endpackage

@@ rtl/gf32pe_if.sv @@
interface gf32pe_in_if import gf32pe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] point;
	logic              restart;

	modport source (output valid, output point, output restart, input ready);
	modport sink (input valid, input point, input restart, output ready);
endinterface

interface gf32pe_out_if import gf32pe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] value;
	logic [DATA_W-1:0] running_xor;

	modport source (output valid, output value, output running_xor, input ready);
	modport sink (input valid, input value, input running_xor, output ready);
endinterface

@@ rtl/gf32_polynomial_evaluator_unit.sv @@
// Polynomial evaluator over GF(2^32), reduction polynomial 0x10000008D.
// Input channel in_ch carries a point x and a restart flag; output channel
// out_ch carries f(x) and the running xor of all f(x) since reset or since
// the last word with restart set. One result word per input word.
// Coefficients coef_0..coef_7 are written through cfg_we/cfg_index/cfg_data;
// indexes beyond 7 are ignored. The user must write them only while the
// block is idle; the block itself does not enforce this. Evaluation uses
// Horner's rule on one shared combinational GF multiplier: the accepting
// cycle loads the top coefficient, then DEGREE (7) steps each do one
// multiply-and-add. A new word is taken only after the last step; in_ch.ready
// is high only while the sequencer is idle.
// The result sits in an output register, so the next word is accepted while
// a result waits. If the receiver stalls, the next evaluation holds its last
// step until the output register is free.
// Reset clears the coefficients, the running xor and all handshake state.
module gf32_polynomial_evaluator_unit import gf32pe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	gf32pe_in_if.sink              in_ch,
	gf32pe_out_if.source           out_ch
);

	logic [DATA_W-1:0]     coef_q [COEF_COUNT];
	state_t                state_q, state_d;
	logic [COEF_IDX_W-1:0] step_q;
	logic [DATA_W-1:0]     acc_q;
	logic [DATA_W-1:0]     point_q;
	logic                  restart_q;
	logic [DATA_W-1:0]     value_q;
	logic [DATA_W-1:0]     running_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     step_res;
	logic                  load;
	logic                  advance;
	logic                  finish;

	assign step_res = gf_mul(acc_q, point_q) ^ coef_q[step_q];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (finish)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		load        = 1'b0;
		advance     = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				load        = in_ch.valid;
			end
			ST_RUN: begin
				advance = (step_q != '0);
				finish  = (step_q == '0) && (!out_valid_q || out_ch.ready);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_COUNT; i++)
				coef_q[i] <= '0;
		end else if (cfg_we && (cfg_index < CFG_INDEX_W'(COEF_COUNT))) begin
			coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			running_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load)
				step_q <= COEF_IDX_W'(DEGREE_USED - 1);
			else if (advance)
				step_q <= step_q - 1'b1;
			if (finish) begin
				out_valid_q <= 1'b1;
				running_q   <= (restart_q ? '0 : running_q) ^ step_res;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q     <= coef_q[DEGREE_USED];
			point_q   <= in_ch.point;
			restart_q <= in_ch.restart;
		end else if (advance) begin
			acc_q <= step_res;
		end
		if (finish)
			value_q <= step_res;
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.value       = value_q;
	assign out_ch.running_xor = running_q;

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == ST_RUN))
		else $error("accepted word did not start evaluation");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !finish)
		else $error("pending result overwritten");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RUN))
		else $error("result raised outside evaluation");

	a_running_xor: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_ch.running_xor ==
			(($past(restart_q) ? '0 : $past(running_q)) ^ out_ch.value)))
		else $error("running xor mismatch");

endmodule
